[rtl/core/ws2812_pkg.sv]
`default_nettype none

package ws2812_pkg;

   localparam int MAX_PIXELS   = 256;
   localparam int PIX_ADDR_W   = $clog2(MAX_PIXELS);
   localparam int PIX_WORD_W   = 24;
   localparam int PIX_COUNT_W  = 9;
   localparam int BIT_TICK_W   = 15;
   localparam int LATCH_TICK_W = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [1:0] OP_SET   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_HIGH  = 2'd1;
   localparam logic [1:0] PH_LOW   = 2'd2;
   localparam logic [1:0] PH_LATCH = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_LOW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_HIGH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_LOW     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LATCH_LOW   = 3'd5;

   typedef struct packed {
      logic [1:0] phase;
      logic       sending;
   } status_type;

endpackage

`default_nettype wire

[rtl/core/ws2812_ram.sv]
`default_nettype none

module ws2812_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/ws2812_led_chain_driver_unit.sv]
// an accepted beat is held pending, with the pixel memory read on acceptance,
//   and executes once the response register is free; its result is registered;
//   no beat is accepted while one is pending, and a stalled result holds the next beat back
// reset: synchronous, active high; pixel valid bits clear at once, so the
//   store reads as all zero immediately with no clearing pass
`default_nettype none

module ws2812_led_chain_driver_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // pixel_index, red, green, blue
   input  wire logic [1:0]  req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // line_level, busy_res, frame_done, zero fill
   input  wire logic                                   csr_wr_en,
   input  wire logic [ws2812_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ws2812_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = ws2812_pkg::PIX_ADDR_W;
   localparam int CW = ws2812_pkg::PIX_COUNT_W;
   localparam int BW = ws2812_pkg::BIT_TICK_W;
   localparam int LW = ws2812_pkg::LATCH_TICK_W;

   logic [CW-1:0] pixel_count_ff;
   logic [BW-1:0] zero_high_ff, zero_low_ff, one_high_ff, one_low_ff;
   logic [LW-1:0] latch_low_ff;

   logic [ws2812_pkg::MAX_PIXELS-1:0] valid_ff, valid_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [1:0]    byte_ff, byte_in;
   logic [2:0]    bit_ff, bit_in;
   logic [LW-1:0] tick_ff, tick_in;
   ws2812_pkg::status_type stat_ff, stat_in;

   logic          pend_ff;
   logic [1:0]    op_ff;
   logic [AW-1:0] idx_ff;
   logic [7:0]    red_ff, green_ff, blue_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_data_ff, rsp_data_in;

   logic          accept, exec;
   logic [CW-1:0] eff_count;
   logic          wr_en;
   logic [ws2812_pkg::PIX_WORD_W-1:0] rd_data, word;
   logic [7:0]    byte_val;
   logic          one_bit;
   logic [LW-1:0] t_sel;
   logic          t_end;
   logic          line, done;

   function automatic logic [LW-1:0] at_least_one(input logic [LW-1:0] v);
      at_least_one = (v == '0) ? LW'(1) : v;
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign exec       = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff;

   assign eff_count = (pixel_count_ff > CW'(ws2812_pkg::MAX_PIXELS)) ?
                      CW'(ws2812_pkg::MAX_PIXELS) : pixel_count_ff;

   assign wr_en = exec && (op_ff == ws2812_pkg::OP_SET) && !stat_ff.sending &&
                  ({1'b0, idx_ff} < eff_count);

   ws2812_ram #(
      .WIDTH(ws2812_pkg::PIX_WORD_W),
      .DEPTH(ws2812_pkg::MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data ({green_ff, red_ff, blue_ff}),
      .rd_en   (accept),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   assign word = valid_ff[cur_ff] ? rd_data : '0;

   always_comb begin
      case (byte_ff)
         2'd0:    byte_val = word[23:16];
         2'd1:    byte_val = word[15:8];
         default: byte_val = word[7:0];
      endcase
      one_bit = byte_val[3'd7 - bit_ff];
   end

   always_comb begin
      case (stat_ff.phase)
         ws2812_pkg::PH_HIGH: t_sel = at_least_one({1'b0, one_bit ? one_high_ff : zero_high_ff});
         ws2812_pkg::PH_LOW:  t_sel = at_least_one({1'b0, one_bit ? one_low_ff : zero_low_ff});
         default:             t_sel = at_least_one(latch_low_ff);
      endcase
      t_end = ({1'b0, tick_ff} + (LW + 1)'(1)) >= {1'b0, t_sel};
   end

   always_comb begin
      valid_in = valid_ff;
      cur_in   = cur_ff;
      byte_in  = byte_ff;
      bit_in   = bit_ff;
      tick_in  = tick_ff;
      stat_in  = stat_ff;
      line     = 1'b0;
      done     = 1'b0;
      if (exec) begin
         if (op_ff == ws2812_pkg::OP_TICK) begin
            if (stat_ff.sending) begin
               unique case (stat_ff.phase)
                  ws2812_pkg::PH_HIGH: begin
                     line = 1'b1;
                     if (t_end) begin
                        tick_in       = '0;
                        stat_in.phase = ws2812_pkg::PH_LOW;
                     end else begin
                        tick_in = tick_ff + LW'(1);
                     end
                  end
                  ws2812_pkg::PH_LOW: begin
                     if (t_end) begin
                        tick_in       = '0;
                        stat_in.phase = ws2812_pkg::PH_HIGH;
                        if (bit_ff != 3'd7) begin
                           bit_in = bit_ff + 3'd1;
                        end else begin
                           bit_in = '0;
                           if (byte_ff < 2'd2) begin
                              byte_in = byte_ff + 2'd1;
                           end else begin
                              byte_in = '0;
                              if (({1'b0, cur_ff} + CW'(1)) < eff_count) begin
                                 cur_in = cur_ff + AW'(1);
                              end else begin
                                 cur_in        = '0;
                                 stat_in.phase = ws2812_pkg::PH_LATCH;
                              end
                           end
                        end
                     end else begin
                        tick_in = tick_ff + LW'(1);
                     end
                  end
                  default: begin
                     if (t_end) begin
                        tick_in         = '0;
                        stat_in.phase   = ws2812_pkg::PH_IDLE;
                        stat_in.sending = 1'b0;
                        done            = 1'b1;
                     end else begin
                        tick_in = tick_ff + LW'(1);
                     end
                  end
               endcase
            end
         end else if (stat_ff.sending) begin
            line = (stat_ff.phase == ws2812_pkg::PH_HIGH);
         end else begin
            unique case (op_ff)
               ws2812_pkg::OP_SET: begin
                  if (wr_en) begin
                     valid_in[idx_ff] = 1'b1;
                  end
               end
               ws2812_pkg::OP_CLEAR: begin
                  valid_in = '0;
               end
               default: begin
                  stat_in.sending = 1'b1;
                  cur_in          = '0;
                  byte_in         = '0;
                  bit_in          = '0;
                  tick_in         = '0;
                  stat_in.phase   = (eff_count == '0) ? ws2812_pkg::PH_LATCH :
                                                        ws2812_pkg::PH_HIGH;
               end
            endcase
         end
      end
      rsp_data_in  = {done, stat_in.sending, line};
      rsp_valid_in = exec ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= CW'(8);
         zero_high_ff   <= BW'(3);
         zero_low_ff    <= BW'(9);
         one_high_ff    <= BW'(6);
         one_low_ff     <= BW'(6);
         latch_low_ff   <= LW'(1000);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ws2812_pkg::REG_PIXEL_COUNT: pixel_count_ff <= csr_wdata[CW-1:0];
            ws2812_pkg::REG_ZERO_HIGH:   zero_high_ff   <= csr_wdata[BW-1:0];
            ws2812_pkg::REG_ZERO_LOW:    zero_low_ff    <= csr_wdata[BW-1:0];
            ws2812_pkg::REG_ONE_HIGH:    one_high_ff    <= csr_wdata[BW-1:0];
            ws2812_pkg::REG_ONE_LOW:     one_low_ff     <= csr_wdata[BW-1:0];
            ws2812_pkg::REG_LATCH_LOW:   latch_low_ff   <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         cur_ff       <= '0;
         byte_ff      <= '0;
         bit_ff       <= '0;
         tick_ff      <= '0;
         stat_ff      <= '{phase: ws2812_pkg::PH_IDLE, sending: 1'b0};
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         cur_ff       <= cur_in;
         byte_ff      <= byte_in;
         bit_ff       <= bit_in;
         tick_ff      <= tick_in;
         stat_ff      <= stat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            pend_ff <= 1'b1;
         end else if (exec) begin
            pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_tuser;
         idx_ff   <= req_tdata[7:0];
         red_ff   <= req_tdata[15:8];
         green_ff <= req_tdata[23:16];
         blue_ff  <= req_tdata[31:24];
      end
      if (exec) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

   a_idle_not_sending: assert property (@(posedge clock) disable iff (reset)
      stat_ff.sending == (stat_ff.phase != ws2812_pkg::PH_IDLE))
      else $error("sending flag and phase disagree");

   a_accept_pends: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_ff && !req_tready)
      else $error("accepted beat not held pending");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[1]))
      else $error("frame done reported while busy");

   a_line_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("line high while not busy");

endmodule

`default_nettype wire
